FILE: rtl/battery_level_monitor_macros.svh
// Assertion macros for the battery level monitor checker.
`ifndef BATTERY_LEVEL_MONITOR_MACROS_SVH
`define BATTERY_LEVEL_MONITOR_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define BLM_ASSERT_NOW(label, ant, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define BLM_ASSERT_NEXT(label, ant, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/blm_pkg.sv
package blm_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILT,
    ST_CHK,
    ST_SCALE,
    ST_RECIP,
    ST_MV,
    ST_SEG,
    ST_DIV,
    ST_PUB
  } blm_state_t;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_MIN_VALID = 2'd0;
  localparam logic [1:0] REG_MAX_VALID = 2'd1;
  localparam logic [1:0] REG_INTERVAL  = 2'd2;
  localparam logic [1:0] REG_CAL       = 2'd3;

  localparam logic [11:0] RST_MIN_VALID = 12'd1500;
  localparam logic [11:0] RST_MAX_VALID = 12'd2200;
  localparam logic [15:0] RST_INTERVAL  = 16'd1000;
  localparam logic [10:0] RST_CAL       = 11'd1000;

  localparam int CURVE_PTS = 9;
  localparam logic [12:0] CURVE_MV [CURVE_PTS] = '{
    13'd3300, 13'd3500, 13'd3600, 13'd3700, 13'd3800,
    13'd3900, 13'd4000, 13'd4100, 13'd4200
  };
  localparam logic [6:0] CURVE_PCT [CURVE_PTS] = '{
    7'd0, 7'd5, 7'd10, 7'd25, 7'd45, 7'd65, 7'd80, 7'd90, 7'd100
  };

  localparam logic [20:0] ROUND_Q8   = 21'd128;
  localparam logic [12:0] MV_LIMIT   = 13'd5000;
  localparam logic [12:0] STEP_MV    = 13'd10;
  localparam logic [6:0]  PCT_FULL   = 7'd100;
  // products at or above this give more than 5000 mV after /1000
  localparam logic [23:0] SAT_PROD   = 24'd5001000;
  // ceil(2^32 / 1000): exact floor division for products up to 6100805
  localparam logic [22:0] RECIP_1000 = 23'd4294968;
  // ceil(2^17 / 100): exact floor division for values up to 2000
  localparam logic [22:0] RECIP_100  = 23'd1311;
  localparam logic [12:0] WIDE_SPAN  = 13'd200;

endpackage

FILE: rtl/battery_level_monitor.sv
// An accepted word passes FILT, CHK, SCALE, RECIP, MV, SEG, DIV and PUB in order;
// a sample rejected by the interval check goes from FILT to PUB, one outside the
// valid window from CHK to PUB. Words are taken one at a time, only in IDLE, and PUB
// waits for out_tready. The single shared multiplier runs four times per valid sample (scale, /1000, curve, /100).
// Reset (synchronous, rst_n low): registers to their defaults, filter, timestamp
// and shown/current values to zero, no result pending.
module battery_level_monitor (
  input  logic        clk,
  input  logic        rst_n,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  // sample stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [11:0] sample_mv, [43:12] now_ms, [47:44] zero
  input  logic [0:0]  in_tuser,   // [0] initialize
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [0] accepted, [13:1] battery_mv,
                                  // [20:14] charge_percent, [21] battery_valid,
                                  // [22] changed, [23] zero
);

  blm_pkg::blm_state_t state_r, state_nxt;

  // config registers
  logic [11:0] min_valid_r, max_valid_r;
  logic [15:0] interval_r;
  logic [10:0] cal_r;

  // architectural state
  logic [19:0] filt_r;
  logic [31:0] last_time_r;
  logic [12:0] shown_mv_r, cur_mv_r;
  logic [6:0]  shown_pct_r, cur_pct_r;
  logic        shown_vld_r, cur_vld_r;

  // per-sample working registers
  logic [11:0] sample_r;
  logic [31:0] now_r;
  logic        init_r;
  logic        acc_r;
  logic [12:0] adc_r;
  logic        vld_r;
  logic [45:0] prod_r;
  logic        sat_r;
  logic [12:0] mv_r;
  logic [6:0]  base_r;
  logic        half_r;

  // result register
  logic        out_tvalid_r;
  logic [23:0] out_tdata_r;

  logic        cfg_wr;
  logic        in_acc;
  logic        pub_go;

  // shared multiplier
  logic [22:0] mul_a, mul_b;
  logic [45:0] mul_p;

  // filter / check
  logic        acc_c;
  logic [31:0] elapsed;
  logic [22:0] f7;
  logic [23:0] fsum;
  logic [19:0] filt_c;
  logic [20:0] rnd;
  logic [12:0] adc_c;
  logic        vld_c;

  // curve segment
  logic [3:0]  seg_k;
  logic [3:0]  seg_lo;
  logic [12:0] seg_off_w;
  logic [7:0]  seg_off;
  logic [6:0]  seg_pspan;
  logic [6:0]  seg_base;
  logic        seg_half;
  logic [11:0] div_x;

  // publish
  logic [4:0]  pct_q;
  logic [12:0] new_mv, res_mv, mv_diff;
  logic [6:0]  new_pct, res_pct;
  logic        res_vld;
  logic        chg;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign in_acc     = in_tvalid & in_tready;
  assign pub_go     = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign mul_p      = mul_a * mul_b;

  always_comb begin
    case (cfg_paddr[3:2])
      blm_pkg::REG_MIN_VALID: cfg_prdata = {20'd0, min_valid_r};
      blm_pkg::REG_MAX_VALID: cfg_prdata = {20'd0, max_valid_r};
      blm_pkg::REG_INTERVAL:  cfg_prdata = {16'd0, interval_r};
      blm_pkg::REG_CAL:       cfg_prdata = {21'd0, cal_r};
      default:                cfg_prdata = 32'd0;
    endcase
  end

  // interval check (wrapping time) and filter update
  always_comb begin
    elapsed = now_r - last_time_r;
    acc_c   = init_r || (elapsed >= {16'd0, interval_r});
    f7      = {filt_r, 3'b000} - {3'b000, filt_r};
    fsum    = {1'b0, f7} + {4'd0, sample_r, 8'd0};
    if (init_r || (filt_r == 20'd0)) begin
      filt_c = {sample_r, 8'd0};
    end else begin
      filt_c = fsum[22:3];
    end
  end

  // rounding and valid window
  always_comb begin
    rnd   = {1'b0, filt_r} + blm_pkg::ROUND_Q8;
    adc_c = rnd[20:8];
    vld_c = (adc_c >= {1'b0, min_valid_r}) && (adc_c <= {1'b0, max_valid_r});
  end

  // discharge curve segment: first point at or above mv
  always_comb begin
    seg_k = 4'(blm_pkg::CURVE_PTS - 1);
    for (int k = blm_pkg::CURVE_PTS - 1; k >= 1; k--) begin
      if (mv_r <= blm_pkg::CURVE_MV[k]) begin
        seg_k = 4'(k);
      end
    end
    seg_lo    = seg_k - 4'd1;
    seg_off_w = mv_r - blm_pkg::CURVE_MV[seg_lo];
    if (mv_r <= blm_pkg::CURVE_MV[0]) begin
      seg_off   = 8'd0;
      seg_pspan = 7'd0;
      seg_base  = blm_pkg::CURVE_PCT[0];
      seg_half  = 1'b0;
    end else if (mv_r >= blm_pkg::CURVE_MV[blm_pkg::CURVE_PTS - 1]) begin
      seg_off   = 8'd0;
      seg_pspan = 7'd0;
      seg_base  = blm_pkg::PCT_FULL;
      seg_half  = 1'b0;
    end else begin
      seg_off   = seg_off_w[7:0];
      seg_pspan = blm_pkg::CURVE_PCT[seg_k] - blm_pkg::CURVE_PCT[seg_lo];
      seg_base  = blm_pkg::CURVE_PCT[seg_lo];
      seg_half  = (blm_pkg::CURVE_MV[seg_k] - blm_pkg::CURVE_MV[seg_lo])
                  == blm_pkg::WIDE_SPAN;
    end
  end

  // 200 mV segments: halve first, then share the /100 step
  assign div_x = half_r ? {1'b0, prod_r[11:1]} : prod_r[11:0];

  // publish decision
  always_comb begin
    pct_q   = prod_r[21:17];
    new_mv  = vld_r ? mv_r : 13'd0;
    new_pct = vld_r ? (base_r + {2'd0, pct_q}) : 7'd0;
    res_mv  = acc_r ? new_mv  : cur_mv_r;
    res_pct = acc_r ? new_pct : cur_pct_r;
    res_vld = acc_r ? vld_r   : cur_vld_r;
    mv_diff = (new_mv >= shown_mv_r) ? (new_mv - shown_mv_r) : (shown_mv_r - new_mv);
    chg     = acc_r && (init_r || (vld_r != shown_vld_r) || (new_pct != shown_pct_r) ||
                        (mv_diff >= blm_pkg::STEP_MV));
  end

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      blm_pkg::ST_IDLE:  if (in_acc) state_nxt = blm_pkg::ST_FILT;
      blm_pkg::ST_FILT:  state_nxt = acc_c ? blm_pkg::ST_CHK : blm_pkg::ST_PUB;
      blm_pkg::ST_CHK:   state_nxt = vld_c ? blm_pkg::ST_SCALE : blm_pkg::ST_PUB;
      blm_pkg::ST_SCALE: state_nxt = blm_pkg::ST_RECIP;
      blm_pkg::ST_RECIP: state_nxt = blm_pkg::ST_MV;
      blm_pkg::ST_MV:    state_nxt = blm_pkg::ST_SEG;
      blm_pkg::ST_SEG:   state_nxt = blm_pkg::ST_DIV;
      blm_pkg::ST_DIV:   state_nxt = blm_pkg::ST_PUB;
      blm_pkg::ST_PUB:   if (pub_go) state_nxt = blm_pkg::ST_IDLE;
      default:           state_nxt = blm_pkg::ST_IDLE;
    endcase
  end

  // sequencer: outputs and multiplier operand select
  always_comb begin
    in_tready = 1'b0;
    mul_a     = 23'd0;
    mul_b     = 23'd0;
    case (state_r)
      blm_pkg::ST_IDLE: begin
        in_tready = rst_n;               // nothing taken while in reset
      end
      blm_pkg::ST_SCALE: begin
        mul_a = {10'd0, adc_r};
        mul_b = {11'd0, cal_r, 1'b0};    // divider doubling folded in
      end
      blm_pkg::ST_RECIP: begin
        mul_a = prod_r[22:0];
        mul_b = blm_pkg::RECIP_1000;
      end
      blm_pkg::ST_SEG: begin
        mul_a = {15'd0, seg_off};
        mul_b = {16'd0, seg_pspan};
      end
      blm_pkg::ST_DIV: begin
        mul_a = {11'd0, div_x};
        mul_b = blm_pkg::RECIP_100;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= blm_pkg::ST_IDLE;
      min_valid_r  <= blm_pkg::RST_MIN_VALID;
      max_valid_r  <= blm_pkg::RST_MAX_VALID;
      interval_r   <= blm_pkg::RST_INTERVAL;
      cal_r        <= blm_pkg::RST_CAL;
      filt_r       <= 20'd0;
      last_time_r  <= 32'd0;
      shown_mv_r   <= 13'd0;
      shown_pct_r  <= 7'd0;
      shown_vld_r  <= 1'b0;
      cur_mv_r     <= 13'd0;
      cur_pct_r    <= 7'd0;
      cur_vld_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          blm_pkg::REG_MIN_VALID: min_valid_r <= cfg_pwdata[11:0];
          blm_pkg::REG_MAX_VALID: max_valid_r <= cfg_pwdata[11:0];
          blm_pkg::REG_INTERVAL:  interval_r  <= cfg_pwdata[15:0];
          blm_pkg::REG_CAL:       cal_r       <= cfg_pwdata[10:0];
          default:                cal_r       <= cal_r;
        endcase
      end
      if ((state_r == blm_pkg::ST_FILT) && acc_c) begin
        filt_r      <= filt_c;
        last_time_r <= now_r;
      end
      if ((state_r == blm_pkg::ST_PUB) && pub_go) begin
        out_tvalid_r <= 1'b1;
        if (acc_r) begin
          cur_mv_r  <= new_mv;
          cur_pct_r <= new_pct;
          cur_vld_r <= vld_r;
        end
        if (chg) begin
          shown_mv_r  <= new_mv;
          shown_pct_r <= new_pct;
          shown_vld_r <= vld_r;
        end
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_tdata[11:0];
      now_r    <= in_tdata[43:12];
      init_r   <= in_tuser[0];
    end
    case (state_r)
      blm_pkg::ST_FILT: begin
        acc_r <= acc_c;
      end
      blm_pkg::ST_CHK: begin
        adc_r <= adc_c;
        vld_r <= vld_c;
      end
      blm_pkg::ST_SCALE: begin
        prod_r <= mul_p;
      end
      blm_pkg::ST_RECIP: begin
        sat_r  <= prod_r[23:0] >= blm_pkg::SAT_PROD;
        prod_r <= mul_p;
      end
      blm_pkg::ST_MV: begin
        mv_r <= sat_r ? blm_pkg::MV_LIMIT : prod_r[44:32];
      end
      blm_pkg::ST_SEG: begin
        base_r <= seg_base;
        half_r <= seg_half;
        prod_r <= mul_p;
      end
      blm_pkg::ST_DIV: begin
        prod_r <= mul_p;
      end
      blm_pkg::ST_PUB: begin
        if (pub_go) begin
          out_tdata_r <= {1'b0, chg, res_vld, res_pct, res_mv, acc_r};
        end
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

endmodule

FILE: rtl/blm_checker.sv
`include "battery_level_monitor_macros.svh"

module blm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // one sample at a time: busy right after taking a word
  `BLM_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready after accept")

  // a stalled result holds
  `BLM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped")

  // only an accepted sample can update the shown values
  `BLM_ASSERT_NOW(a_chg_needs_acc, out_tvalid && out_tdata[22], out_tdata[0], "changed without accept")

  // outside the window both readings are zero
  `BLM_ASSERT_NOW(a_invalid_zero, out_tvalid && !out_tdata[21], out_tdata[20:1] == 20'd0, "invalid nonzero")

  // saturation and curve limits
  `BLM_ASSERT_NOW(a_range, out_tvalid, (out_tdata[13:1] <= 13'd5000) && (out_tdata[20:14] <= 7'd100), "range")

endmodule

bind battery_level_monitor blm_checker u_blm_checker (.*);

FILE: tb/battery_level_monitor_tb.sv
`timescale 1ns / 1ps

module battery_level_monitor_tb;

  // Result word as it sits in out_tdata[22:0], lowest field last.
  typedef struct packed {
    logic        changed;
    logic        battery_valid;
    logic [6:0]  charge_percent;
    logic [12:0] battery_mv;
    logic        accepted;
  } reading_t;

  // One directed sample; want is only used when fixed is set.
  typedef struct {
    logic [11:0] sample;
    logic [31:0] now;
    logic        init;
    logic        fixed;
    reading_t    want;
  } dir_row_t;

  localparam int PHASES          = 7;
  localparam int ITEMS_PER_PHASE = 220;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // [11:0] sample_mv, [43:12] now_ms, [47:44] zero
  logic [0:0]  in_tuser = '0;   // [0] initialize
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [0] accepted, [13:1] battery_mv, [20:14] charge_percent,
                                // [21] battery_valid, [22] changed, [23] zero

  battery_level_monitor uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #1000000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Monitor model: register copies and filter / display state
  // ---------------------------------------------------------------------
  logic [11:0] win_lo, win_hi;
  logic [15:0] gap_ms;
  logic [10:0] gain_pm;
  logic [19:0] filt_q8;
  logic [31:0] last_ms;
  logic [12:0] shown_mv, cur_mv;
  logic [6:0]  shown_pct, cur_pct;
  logic        shown_ok, cur_ok;

  reading_t pending_q[$];   // readings still owed by the block, oldest first
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned feed_calm = 0;   // words left in a no-gap burst, sender side
  int unsigned sink_calm = 0;   // same for the receiver

  // Advances the model by one sample word and returns the reading it yields.
  function automatic reading_t step_monitor(logic [11:0] s, logic [31:0] now, logic init);
    reading_t    r;
    logic [31:0] since, q8_in, acc, adc, mv, pct_w, lo_mv, hi_mv, lo_pct, hi_pct;
    logic [12:0] moved;
    int          seg;
    r = '0;
    since = now - last_ms;
    if (init || since >= {16'd0, gap_ms}) begin
      last_ms = now;
      // Q8 filter: direct load on init or from empty, else EMA with alpha 1/8
      q8_in = {20'd0, s} << 8;
      if (init || filt_q8 == '0)
        acc = q8_in;
      else
        acc = ({12'd0, filt_q8} * 32'd7 + q8_in) / 32'd8;
      filt_q8 = acc[19:0];
      adc = ({12'd0, filt_q8} + {11'd0, blm_pkg::ROUND_Q8}) >> 8;
      cur_ok = (adc >= {20'd0, win_lo}) && (adc <= {20'd0, win_hi});
      if (!cur_ok) begin
        cur_mv = '0;
        cur_pct = '0;
      end else begin
        // divider doubling, then gain in per mille, clamp
        mv = adc * 32'd2 * {21'd0, gain_pm} / 32'd1000;
        if (mv > {19'd0, blm_pkg::MV_LIMIT}) mv = {19'd0, blm_pkg::MV_LIMIT};
        if (mv <= {19'd0, blm_pkg::CURVE_MV[0]}) begin
          pct_w = '0;
        end else if (mv >= {19'd0, blm_pkg::CURVE_MV[blm_pkg::CURVE_PTS-1]}) begin
          pct_w = {25'd0, blm_pkg::PCT_FULL};
        end else begin
          // first curve point at or above mv, interpolate from the one below
          seg = blm_pkg::CURVE_PTS - 1;
          for (int k = blm_pkg::CURVE_PTS - 1; k >= 1; k--)
            if (mv <= {19'd0, blm_pkg::CURVE_MV[k]}) seg = k;
          lo_mv = {19'd0, blm_pkg::CURVE_MV[seg-1]};
          hi_mv = {19'd0, blm_pkg::CURVE_MV[seg]};
          lo_pct = {25'd0, blm_pkg::CURVE_PCT[seg-1]};
          hi_pct = {25'd0, blm_pkg::CURVE_PCT[seg]};
          pct_w = lo_pct + (mv - lo_mv) * (hi_pct - lo_pct) / (hi_mv - lo_mv);
        end
        cur_mv = mv[12:0];
        cur_pct = pct_w[6:0];
      end
      r.accepted = 1'b1;
      moved = (cur_mv >= shown_mv) ? cur_mv - shown_mv : shown_mv - cur_mv;
      r.changed = init || (cur_ok != shown_ok) || (cur_pct != shown_pct) ||
                  (moved >= blm_pkg::STEP_MV);
    end
    if (r.changed) begin
      shown_mv = cur_mv;
      shown_pct = cur_pct;
      shown_ok = cur_ok;
    end
    r.battery_mv = cur_mv;
    r.charge_percent = cur_pct;
    r.battery_valid = cur_ok;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch on %s: got %0d, expected %0d at %0t ns", what, got, want, $time);
  endtask

  // ---------------------------------------------------------------------
  // Register access: write, then read back; model copy updated alongside
  // ---------------------------------------------------------------------
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    logic [31:0] kept;
    kept = '0;
    case (idx)
      blm_pkg::REG_MIN_VALID: begin
        win_lo = val[11:0];
        kept = {20'd0, val[11:0]};
      end
      blm_pkg::REG_MAX_VALID: begin
        win_hi = val[11:0];
        kept = {20'd0, val[11:0]};
      end
      blm_pkg::REG_INTERVAL: begin
        gap_ms = val[15:0];
        kept = {16'd0, val[15:0]};
      end
      blm_pkg::REG_CAL: begin
        gain_pm = val[10:0];
        kept = {21'd0, val[10:0]};
      end
      default: ;
    endcase
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    if (cfg_prdata !== kept) report_mismatch("register readback", cfg_prdata, kept);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Sample feed. Leaves in_tvalid high on return so a back-to-back word
  // needs only one assignment; the caller lowers it at the end of a phase.
  // ---------------------------------------------------------------------
  task automatic feed_word(logic [11:0] s, logic [31:0] now, logic init,
                           logic fixed, reading_t want);
    int unsigned wait_cycles;
    if (feed_calm > 0) begin
      wait_cycles = 0;
      feed_calm--;
    end else begin
      wait_cycles = $urandom_range(0, 10);
      if ($urandom_range(0, 15) == 0) feed_calm = $urandom_range(10, 40);
    end
    if (wait_cycles > 0) begin
      in_tvalid <= 1'b0;
      repeat (wait_cycles) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, now, s};
    in_tuser <= init;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    // word taken at this edge: the model steps in acceptance order
    if (fixed) begin
      void'(step_monitor(s, now, init));
      pending_q.push_back(want);
    end else begin
      pending_q.push_back(step_monitor(s, now, init));
    end
  endtask

  function automatic void add_row(ref dir_row_t rows[$], input logic [11:0] s,
                                  input logic [31:0] now, input logic init,
                                  input logic fixed, input logic acc,
                                  input logic [12:0] mv, input logic [6:0] pct,
                                  input logic ok, input logic chg);
    dir_row_t row;
    row.sample = s;
    row.now = now;
    row.init = init;
    row.fixed = fixed;
    row.want = {chg, ok, pct, mv, acc};
    rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------
  // Result sink: random backpressure, two long hold-offs so the block
  // backs up and stalls its input while the feed keeps offering words.
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int unsigned wait_cycles;
    reading_t    got, want;
    wait (rst_n === 1'b1);
    forever begin
      if (results_seen == 300 || results_seen == 1100) begin
        wait_cycles = 400;
      end else if (sink_calm > 0) begin
        wait_cycles = 0;
        sink_calm--;
      end else begin
        wait_cycles = $urandom_range(0, 10);
        if ($urandom_range(0, 15) == 0) sink_calm = $urandom_range(10, 40);
      end
      if (wait_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
      got = reading_t'(out_tdata[22:0]);
      results_seen++;
      if (pending_q.size() == 0) begin
        report_mismatch("word with nothing pending", 32'(got), 32'd0);
      end else begin
        want = pending_q.pop_front();
        if (got.accepted !== want.accepted)
          report_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
        if (got.battery_mv !== want.battery_mv)
          report_mismatch("battery_mv", 32'(got.battery_mv), 32'(want.battery_mv));
        if (got.charge_percent !== want.charge_percent)
          report_mismatch("charge_percent", 32'(got.charge_percent),
                          32'(want.charge_percent));
        if (got.battery_valid !== want.battery_valid)
          report_mismatch("battery_valid", 32'(got.battery_valid),
                          32'(want.battery_valid));
        if (got.changed !== want.changed)
          report_mismatch("changed", 32'(got.changed), 32'(want.changed));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t    rows[$];
    logic [31:0] plan [PHASES][4];
    logic [11:0] s;
    logic [31:0] now;
    logic        init;
    int          pick, lo, hi, lo_w, hi_w;

    // model at reset
    win_lo = blm_pkg::RST_MIN_VALID;
    win_hi = blm_pkg::RST_MAX_VALID;
    gap_ms = blm_pkg::RST_INTERVAL;
    gain_pm = blm_pkg::RST_CAL;
    filt_q8 = '0;
    last_ms = '0;
    shown_mv = '0;
    cur_mv = '0;
    shown_pct = '0;
    cur_pct = '0;
    shown_ok = 1'b0;
    cur_ok = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words, reset register values (window 1500..2200, 1000 ms, x1.000).
    //            sample  now            init fixed  acc  mv    pct  ok  chg
    // nothing accepted yet and time 0: too early, all zero
    add_row(rows, 12'd1800, 32'd0,          0, 1,   0, 0,    0,   0, 0);
    // empty filter loads directly; 3600 mV sits on a curve point
    add_row(rows, 12'd1800, 32'd1000,       0, 1,   1, 3600, 10,  1, 1);
    // one ms short of the interval
    add_row(rows, 12'd1800, 32'd1999,       0, 1,   0, 3600, 10,  1, 0);
    // exactly the interval; steady input leaves the filter unchanged
    add_row(rows, 12'd1800, 32'd2000,       0, 1,   1, 3600, 10,  1, 0);
    // full-scale and zero samples on initialize: outside the window
    add_row(rows, 12'd4095, 32'd2000,       1, 1,   1, 0,    0,   0, 1);
    add_row(rows, 12'd0,    32'd2001,       1, 1,   1, 0,    0,   0, 1);
    // filter left at zero, so a plain sample reloads it; top of window, above curve
    add_row(rows, 12'd2200, 32'd3001,       0, 1,   1, 4400, 100, 1, 1);
    // window edges
    add_row(rows, 12'd1500, 32'd3001,       1, 1,   1, 3000, 0,   1, 1);
    add_row(rows, 12'd1499, 32'd3002,       1, 1,   1, 0,    0,   0, 1);
    add_row(rows, 12'd2201, 32'd3003,       1, 1,   1, 0,    0,   0, 1);
    add_row(rows, 12'd1750, 32'd3004,       1, 1,   1, 3500, 5,   1, 1);
    // EMA step, then a sample inside the interval
    add_row(rows, 12'd1650, 32'd4004,       0, 0,   0, 0,    0,   0, 0);
    add_row(rows, 12'd1650, 32'd4900,       0, 0,   0, 0,    0,   0, 0);
    // time wraps through zero: 768 ms is short, 1000 ms is enough
    add_row(rows, 12'd1900, 32'hFFFF_FE00,  1, 1,   1, 3800, 45,  1, 1);
    add_row(rows, 12'd1900, 32'h0000_0100,  0, 1,   0, 3800, 45,  1, 0);
    add_row(rows, 12'd2100, 32'h0000_01E8,  0, 0,   0, 0,    0,   0, 0);
    add_row(rows, 12'd4095, 32'hFFFF_FFFF,  1, 1,   1, 0,    0,   0, 1);
    add_row(rows, 12'd1234, 32'hFFFF_FFFF,  0, 1,   0, 0,    0,   0, 0);
    add_row(rows, 12'd3000, 32'h0000_03E7,  0, 0,   0, 0,    0,   0, 0);
    // small move below the 10 mV step: no publish expected
    add_row(rows, 12'd1900, 32'd10000,      1, 1,   1, 3800, 45,  1, 1);
    add_row(rows, 12'd1903, 32'd11000,      0, 0,   0, 0,    0,   0, 0);

    foreach (rows[i])
      feed_word(rows[i].sample, rows[i].now, rows[i].init, rows[i].fixed, rows[i].want);
    in_tvalid <= 1'b0;

    // Register settings per phase: min, max, interval, calibration.
    // full window, zero interval, gain beyond 2.000 (clamps at 5000 mV)
    plan[0] = '{32'd0,    32'd4095, 32'd0,     32'd2047};
    // inverted window (never valid), longest interval
    plan[1] = '{32'd3000, 32'd1000, 32'd65535, 32'd2000};
    // zero gain, one ms interval
    plan[2] = '{32'd1600, 32'd2150, 32'd1,     32'd0};
    plan[3] = '{32'd1500, 32'd2200, 32'd1000,  32'd1000};
    for (int p = 4; p < PHASES; p++) begin
      plan[p][0] = $urandom_range(1200, 1800);
      plan[p][1] = plan[p][0] + $urandom_range(100, 800);
      plan[p][2] = $urandom_range(0, 3000);
      plan[p][3] = $urandom_range(800, 1200);
    end

    for (int p = 0; p < PHASES; p++) begin
      // block is idle once every reading is back (each word yields one)
      while (pending_q.size() != 0) @(posedge clk);
      write_reg(blm_pkg::REG_MIN_VALID, plan[p][0]);
      write_reg(blm_pkg::REG_MAX_VALID, plan[p][1]);
      write_reg(blm_pkg::REG_INTERVAL,  plan[p][2]);
      write_reg(blm_pkg::REG_CAL,       plan[p][3]);
      lo = (win_lo < win_hi) ? int'(win_lo) : int'(win_hi);
      hi = (win_lo < win_hi) ? int'(win_hi) : int'(win_lo);
      lo_w = (lo > 60) ? lo - 60 : 0;
      hi_w = (hi + 60 > 4095) ? 4095 : hi + 60;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // mostly samples around the window so the filter tracks the curve
        if ($urandom_range(0, 3) == 0)
          s = 12'($urandom_range(0, 4095));
        else
          s = 12'($urandom_range(lo_w, hi_w));
        // timing: mostly just past the interval, some early, some edge,
        // a few initialize words and a few jumps to arbitrary time
        pick = $urandom_range(0, 99);
        init = (pick < 8);
        if (pick < 8)
          now = last_ms + $urandom_range(0, 50);
        else if (pick < 78)
          now = last_ms + {16'd0, gap_ms} + $urandom_range(0, 40);
        else if (pick < 84)
          now = last_ms + {16'd0, gap_ms} - 32'd1;
        else if (pick < 95)
          now = last_ms + $urandom_range(0, {16'd0, gap_ms});
        else
          now = $urandom;
        feed_word(s, now, init, 1'b0, '0);
      end
      in_tvalid <= 1'b0;
    end

    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/blm_pkg.sv
rtl/battery_level_monitor.sv
rtl/blm_checker.sv
tb/battery_level_monitor_tb.sv
